>>> rtl/lpht_pkg.sv
package lpht_pkg;

    // Microprogram counter width and step addresses.
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_CLEAR    = 4'd0;
    localparam t_pc PC_IDLE     = 4'd1;
    localparam t_pc PC_HASH     = 4'd2;
    localparam t_pc PC_DISPATCH = 4'd3;
    localparam t_pc PC_INS_TEST = 4'd4;
    localparam t_pc PC_INS_READ = 4'd5;
    localparam t_pc PC_INS_EVAL = 4'd6;
    localparam t_pc PC_INS_DONE = 4'd7;
    localparam t_pc PC_LK_TEST  = 4'd8;
    localparam t_pc PC_LK_READ  = 4'd9;
    localparam t_pc PC_LK_EVAL  = 4'd10;
    localparam t_pc PC_PUSH     = 4'd11;
    localparam t_pc PC_WAIT     = 4'd12;

    // Datapath operation selected by one control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_ACCEPT,
        OP_HASH,
        OP_INS_READ,
        OP_INS_EVAL,
        OP_LK_READ,
        OP_LK_EVAL,
        OP_PUSH
    } t_op;

    // Jump condition: when true, go to the target step, otherwise to the next one.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_CLR_BUSY,
        C_NO_INPUT,
        C_HASH_BUSY,
        C_LOOKUP,
        C_LP_FULL,
        C_INS_MISS,
        C_LK_STOP,
        C_LK_MISS,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    // Status flags from the datapath that the jump conditions test.
    typedef struct packed {
        logic clr_last;
        logic in_valid;
        logic hash_last;
        logic is_lookup;
        logic lp_full;
        logic ins_miss;
        logic lk_stop;
        logic lk_miss;
        logic out_free;
    } t_flags;

    // Read-only microprogram.
    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl w;
        case (pc)
            PC_CLEAR:    w = '{OP_CLEAR,    C_CLR_BUSY,  PC_CLEAR};
            PC_IDLE:     w = '{OP_ACCEPT,   C_NO_INPUT,  PC_IDLE};
            PC_HASH:     w = '{OP_HASH,     C_HASH_BUSY, PC_HASH};
            PC_DISPATCH: w = '{OP_NOP,      C_LOOKUP,    PC_LK_TEST};
            PC_INS_TEST: w = '{OP_NOP,      C_LP_FULL,   PC_PUSH};
            PC_INS_READ: w = '{OP_INS_READ, C_NEVER,     PC_IDLE};
            PC_INS_EVAL: w = '{OP_INS_EVAL, C_INS_MISS,  PC_INS_TEST};
            PC_INS_DONE: w = '{OP_NOP,      C_ALWAYS,    PC_PUSH};
            PC_LK_TEST:  w = '{OP_NOP,      C_LK_STOP,   PC_PUSH};
            PC_LK_READ:  w = '{OP_LK_READ,  C_NEVER,     PC_IDLE};
            PC_LK_EVAL:  w = '{OP_LK_EVAL,  C_LK_MISS,   PC_LK_TEST};
            PC_PUSH:     w = '{OP_PUSH,     C_OUT_FREE,  PC_IDLE};
            PC_WAIT:     w = '{OP_NOP,      C_ALWAYS,    PC_PUSH};
            default:     w = '{OP_NOP,      C_ALWAYS,    PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/linear_probe_hash_table.sv
// Flow: a request is accepted, its home slot is hashed from the key, and the probe loop
// of the microprogram reads slot after slot until the key turns up or the run limit
// is met; an insert also stops at an empty slot. Transactions run one at a time: no
// new request is accepted until the result has been pushed out, and a push that finds
// the output held waits and retries.
// Reset: synchronous, active low; afterwards the key store is cleared one slot
// per cycle, and no transaction is accepted until the clearing is done.
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic        [31:0] i_key,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_status,
    output logic signed [31:0] o_read_value,
    output logic        [8:0]  o_entry_count
);

    t_ctrl  ctrl;
    t_flags flags;

    // Microprogram sequencer.
    lpht_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    // Datapath with key and value stores.
    lpht_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_flags       (flags),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

endmodule

>>> rtl/lpht_seq.sv
module lpht_seq
    import lpht_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl w_ctrl;
    logic  w_take;

    // Fetch the control word for the current step.
    assign w_ctrl = ucode(r_pc);
    assign o_ctrl = w_ctrl;

    // Evaluate the jump condition of this step.
    always_comb begin
        case (w_ctrl.cond)
            C_NEVER:     w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_CLR_BUSY:  w_take = !i_flags.clr_last;
            C_NO_INPUT:  w_take = !i_flags.in_valid;
            C_HASH_BUSY: w_take = !i_flags.hash_last;
            C_LOOKUP:    w_take = i_flags.is_lookup;
            C_LP_FULL:   w_take = i_flags.lp_full;
            C_INS_MISS:  w_take = i_flags.ins_miss;
            C_LK_STOP:   w_take = i_flags.lk_stop;
            C_LK_MISS:   w_take = i_flags.lk_miss;
            C_OUT_FREE:  w_take = i_flags.out_free;
            default:     w_take = 1'b0;
        endcase
    end

    // Next step: the jump target or the following word.
    always_comb begin
        n_pc = w_take ? w_ctrl.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> rtl/lpht_dp.sv
module lpht_dp
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl              i_ctrl,
    output t_flags             o_flags,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic        [31:0] i_key,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_status,
    output logic signed [31:0] o_read_value,
    output logic        [8:0]  o_entry_count
);

    localparam int SW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SIZE - 1);
    localparam logic [SW:0]   MODULUS   = (SW + 1)'(TABLE_SIZE - 1);
    localparam logic [CW-1:0] FULL_RUN  = CW'(TABLE_SIZE);

    // Stores.
    logic        [31:0] key_mem [TABLE_SIZE];
    logic signed [31:0] val_mem [TABLE_SIZE];

    // Registers.
    logic        [SW-1:0] r_clr_idx, n_clr_idx;
    logic                 r_cmd,     n_cmd;
    logic        [31:0]   r_key,     n_key;
    logic signed [31:0]   r_value,   n_value;
    logic        [31:0]   r_hkey,    n_hkey;
    logic        [1:0]    r_hcnt,    n_hcnt;
    logic        [SW-1:0] r_slot,    n_slot;
    logic        [CW-1:0] r_probes,  n_probes;
    logic        [CW-1:0] r_longest, n_longest;
    logic        [8:0]    r_count,   n_count;
    logic                 r_status,  n_status;
    logic signed [31:0]   r_result,  n_result;
    logic                 r_ovalid,  n_ovalid;
    logic                 r_ostatus, n_ostatus;
    logic signed [31:0]   r_oval,    n_oval;
    logic        [8:0]    r_ocount,  n_ocount;
    logic        [31:0]   r_rd_key;
    logic signed [31:0]   r_rd_val;

    // Memory port controls.
    logic          key_we;
    logic [SW-1:0] key_waddr;
    logic [31:0]   key_wdata;
    logic          val_we;
    logic          key_re;
    logic          val_re;

    logic [SW:0]   hash_rem;
    logic [SW-1:0] next_slot;
    logic          out_free;

    // Home slot: eight bits of the key per cycle, restoring remainder.
    always_comb begin
        hash_rem = {1'b0, r_slot};
        for (int i = 0; i < 8; i++) begin
            hash_rem = {hash_rem[SW-1:0], r_hkey[31-i]};
            if (hash_rem >= MODULUS) begin
                hash_rem = hash_rem - MODULUS;
            end
        end
    end

    assign next_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    assign out_free  = !r_ovalid || i_out_ready;

    // Flags for the sequencer.
    always_comb begin
        o_flags.clr_last  = (r_clr_idx == LAST_SLOT);
        o_flags.in_valid  = i_in_valid;
        o_flags.hash_last = (r_hcnt == 2'd3);
        o_flags.is_lookup = r_cmd;
        o_flags.lp_full   = (r_longest == FULL_RUN);
        o_flags.ins_miss  = (r_rd_key != r_key) && (r_rd_key != '0);
        o_flags.lk_stop   = (r_key == '0) || (r_probes == r_longest);
        o_flags.lk_miss   = (r_rd_key != r_key);
        o_flags.out_free  = out_free;
    end

    assign o_in_ready = (i_ctrl.op == OP_ACCEPT);

    // Datapath next values, selected by the current operation.
    always_comb begin
        n_clr_idx = r_clr_idx;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_value   = r_value;
        n_hkey    = r_hkey;
        n_hcnt    = r_hcnt;
        n_slot    = r_slot;
        n_probes  = r_probes;
        n_longest = r_longest;
        n_count   = r_count;
        n_status  = r_status;
        n_result  = r_result;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_ostatus = r_ostatus;
        n_oval    = r_oval;
        n_ocount  = r_ocount;
        key_we    = 1'b0;
        key_waddr = r_slot;
        key_wdata = r_key;
        val_we    = 1'b0;
        key_re    = 1'b0;
        val_re    = 1'b0;
        case (i_ctrl.op)
            OP_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = r_clr_idx;
                key_wdata = '0;
                n_clr_idx = r_clr_idx + 1'b1;
            end
            OP_ACCEPT: begin
                if (i_in_valid) begin
                    n_cmd    = i_command;
                    n_key    = i_key;
                    n_value  = i_value;
                    n_hkey   = i_key;
                    n_hcnt   = '0;
                    n_slot   = '0;
                    n_probes = '0;
                    n_status = 1'b1;
                    n_result = '0;
                end
            end
            OP_HASH: begin
                n_slot = hash_rem[SW-1:0];
                n_hkey = {r_hkey[23:0], 8'd0};
                n_hcnt = r_hcnt + 1'b1;
            end
            OP_INS_READ: begin
                if (r_probes == r_longest) begin
                    n_longest = r_longest + 1'b1;
                end
                n_probes = r_probes + 1'b1;
                key_re   = 1'b1;
            end
            OP_INS_EVAL: begin
                if (r_rd_key == r_key) begin
                    n_status = 1'b0;
                end else if (r_rd_key == '0) begin
                    key_we   = 1'b1;
                    val_we   = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_status = 1'b0;
                end else begin
                    n_slot = next_slot;
                end
            end
            OP_LK_READ: begin
                n_probes = r_probes + 1'b1;
                key_re   = 1'b1;
                val_re   = 1'b1;
            end
            OP_LK_EVAL: begin
                if (r_rd_key == r_key) begin
                    n_status = 1'b0;
                    n_result = r_rd_val;
                end else begin
                    n_slot = next_slot;
                end
            end
            OP_PUSH: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oval    = r_result;
                    n_ocount  = r_count;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_longest <= '0;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_clr_idx <= n_clr_idx;
            r_longest <= n_longest;
            r_count   <= n_count;
            r_ovalid  <= n_ovalid;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_value   <= n_value;
        r_hkey    <= n_hkey;
        r_hcnt    <= n_hcnt;
        r_slot    <= n_slot;
        r_probes  <= n_probes;
        r_status  <= n_status;
        r_result  <= n_result;
        r_ostatus <= n_ostatus;
        r_oval    <= n_oval;
        r_ocount  <= n_ocount;
    end

    // Key and value stores: one access per cycle, registered read data.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (val_we) begin
            val_mem[r_slot] <= r_value;
        end
        if (key_re) begin
            r_rd_key <= key_mem[r_slot];
        end
        if (val_re) begin
            r_rd_val <= val_mem[r_slot];
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_read_value  = r_oval;
    assign o_entry_count = r_ocount;

endmodule

>>> tb/linear_probe_hash_table_tb.sv
module linear_probe_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS         = 256;
    localparam int POOL_SIZE     = 150;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int FULL_ITEMS    = 40;
    localparam int FRESH_LIMIT   = 180;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 50;
    localparam int CYCLE_LIMIT   = 8_000_000;
    // Largest multiplier m for which home + (SLOTS - 1) * m still fits in 32 bits.
    localparam int MAX_HOME_STEP = 16843008;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_FAIL    = 1'b1;

    typedef struct packed {
        logic               status;
        logic signed [31:0] read_value;
        logic [8:0]         entry_count;
    } t_table_reply;

    // Mirror of the table contents and the queue of replies still owed by the block.
    class hash_table_mirror;
        logic [31:0]        slot_key [SLOTS];
        logic signed [31:0] slot_value [SLOTS];
        logic [8:0]         stored_count;
        int                 longest_run;
        t_table_reply       pending_replies [$];
        int                 mismatches;

        function new();
            foreach (slot_key[i]) begin
                slot_key[i] = '0;
                slot_value[i] = '0;
            end
            stored_count = '0;
            longest_run = 0;
            mismatches = 0;
        endfunction

        // Work out the reply to one accepted request and update the mirrored table.
        function void note_request(logic cmd, logic [31:0] k, logic signed [31:0] v);
            t_table_reply reply;
            int slot;
            int probes;
            reply.status = ST_FAIL;
            reply.read_value = '0;
            slot = int'(k % (SLOTS - 1));
            probes = 0;
            if (cmd == CMD_INSERT) begin
                // Walk forward until the key or an empty slot turns up, or the run limit hits.
                while (longest_run < SLOTS) begin
                    if (probes == longest_run) begin
                        longest_run++;
                    end
                    probes++;
                    if (slot_key[slot] == k) begin
                        reply.status = ST_OK;
                        break;
                    end
                    if (slot_key[slot] == '0) begin
                        slot_key[slot] = k;
                        slot_value[slot] = v;
                        stored_count++;
                        reply.status = ST_OK;
                        break;
                    end
                    slot = (slot == SLOTS - 1) ? 0 : slot + 1;
                end
            end else if (k != '0) begin
                // A lookup never probes further than the longest run seen so far.
                for (int i = 0; i < longest_run; i++) begin
                    if (slot_key[slot] == k) begin
                        reply.status = ST_OK;
                        reply.read_value = slot_value[slot];
                        break;
                    end
                    slot = (slot == SLOTS - 1) ? 0 : slot + 1;
                end
            end
            reply.entry_count = stored_count;
            pending_replies.push_back(reply);
        endfunction

        // Compare one reply from the block with the oldest one owed.
        function void check_reply(logic status, logic signed [31:0] rd, logic [8:0] count);
            t_table_reply want;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected transaction: status %0d, read value %0d, count %0d",
                         $time, status, rd, count);
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status) begin
                $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
                mismatches++;
            end
            if (rd !== want.read_value) begin
                $display("%0t: read value expected %0d, actual %0d",
                         $time, want.read_value, rd);
                mismatches++;
            end
            if (count !== want.entry_count) begin
                $display("%0t: entry count expected %0d, actual %0d",
                         $time, want.entry_count, count);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_command = CMD_INSERT;
    logic        [31:0] i_key = '0;
    logic signed [31:0] i_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_status;
    logic signed [31:0] o_read_value;
    logic        [8:0]  o_entry_count;

    hash_table_mirror mirror;
    logic [31:0]      key_pool [POOL_SIZE];
    bit               wrap_case;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    bit               hold_req = 1'b0;
    bit               hold_done = 1'b0;
    int               hold_left = 0;
    int               cycle_count = 0;

    linear_probe_hash_table #(
        .TABLE_SIZE(SLOTS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_entry_count(o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Give up on a hung block.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver side: random stalls, plus one long hold-off that backs the block up.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Every result transaction is checked against the mirror.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            mirror.check_reply(o_status, o_read_value, o_entry_count);
        end
    end

    // Offer one request, idling first at the current rate, and return once it is taken.
    task automatic send_item(input logic cmd, input logic [31:0] k,
                             input logic signed [31:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_key <= k;
        i_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        mirror.note_request(cmd, k, v);
    endtask

    // Mostly inserts and lookups from the key pool, with fresh keys and key zero mixed in.
    task automatic pick_item(output logic cmd, output logic [31:0] k,
                             output logic signed [31:0] v);
        int r;
        r = $urandom_range(0, 99);
        v = $urandom;
        k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 2) begin
            cmd = CMD_INSERT;
            k = '0;
        end else if (r < 4) begin
            cmd = CMD_LOOKUP;
            k = '0;
        end else if (r < 44) begin
            cmd = CMD_INSERT;
        end else if (r < 84) begin
            cmd = CMD_LOOKUP;
        end else begin
            // Fresh keys are stored only while the load stays moderate.
            k = $urandom;
            cmd = (r < 89 && mirror.stored_count < FRESH_LIMIT) ? CMD_INSERT : CMD_LOOKUP;
        end
    endtask

    initial begin
        logic               c;
        logic [31:0]        k;
        logic signed [31:0] v;
        mirror = new();
        wrap_case = 1'($urandom_range(0, 1));

        // Key pool: random keys, keys sharing a home slot, and in some runs keys at the top end.
        for (int i = 0; i < POOL_SIZE; i++) begin
            case (i % 4)
                0: key_pool[i] = $urandom;
                1: key_pool[i] = wrap_case ?
                       254 + (SLOTS - 1) * $urandom_range(1, MAX_HOME_STEP) : $urandom;
                default: key_pool[i] = key_pool[$urandom_range(0, i - 1)] +
                                       (SLOTS - 1) * $urandom_range(1, 1000);
            endcase
            if (key_pool[i] == '0) begin
                key_pool[i] = 32'd1;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests.
        send_idle_pct = 24;
        stall_pct = 24;
        send_item(CMD_LOOKUP, 32'd5, 32'sd0);
        send_item(CMD_LOOKUP, 32'd0, -32'sd1);
        // Inserting key zero finds an empty slot and counts as already present.
        send_item(CMD_INSERT, 32'd0, 32'sd17);
        send_item(CMD_INSERT, 32'd1, 32'sh7FFF_FFFF);
        send_item(CMD_INSERT, 32'd256, 32'sh8000_0000);
        send_item(CMD_INSERT, 32'd1, -32'sd1);
        send_item(CMD_LOOKUP, 32'd1, 32'sd0);
        send_item(CMD_LOOKUP, 32'd256, 32'sd0);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, -32'sd1);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        send_item(CMD_LOOKUP, 32'd511, 32'sd0);
        send_item(CMD_INSERT, 32'd0, 32'sd0);
        send_item(CMD_LOOKUP, 32'd0, 32'sd0);
        send_item(CMD_INSERT, 32'h8000_0000, 32'sd0);
        send_item(CMD_LOOKUP, 32'h8000_0000, -32'sd1);
        if (wrap_case) begin
            // A chain through the last slot that wraps to slot zero.
            send_item(CMD_INSERT, 32'd254, 32'sd254);
            send_item(CMD_INSERT, 32'd509, 32'sd509);
            send_item(CMD_INSERT, 32'd764, 32'sd764);
            send_item(CMD_LOOKUP, 32'd764, 32'sd0);
            send_item(CMD_LOOKUP, 32'd1019, 32'sd0);
        end

        // Random requests in four flow-control phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 80; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 80; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                if (phase == 0 && n == 10) begin
                    hold_req = 1'b1;
                end
                pick_item(c, k, v);
                send_item(c, k, v);
            end
        end

        // Fill every empty slot below the last one straight at its home.
        send_idle_pct = 24;
        stall_pct = 24;
        for (int s = 0; s < SLOTS - 1; s++) begin
            if (mirror.slot_key[s] == '0) begin
                k = s + (SLOTS - 1) * $urandom_range(1, MAX_HOME_STEP);
                send_item(CMD_INSERT, k, $urandom);
            end
        end
        // Key zero now walks every slot and pushes the run to the table size.
        send_item(CMD_INSERT, 32'd0, $urandom);

        // With the table full, inserts fail while lookups keep working.
        for (int n = 0; n < FULL_ITEMS; n++) begin
            pick_item(c, k, v);
            send_item(c, k, v);
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then watch for strays.
        while (mirror.pending_replies.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mirror.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/lpht_pkg.sv
rtl/lpht_seq.sv
rtl/lpht_dp.sv
rtl/linear_probe_hash_table.sv
tb/linear_probe_hash_table_tb.sv
